FILE: rtl/core/assert_macros.svh
// Assertion macros shared by the histogram RTL.
// Relies on clk and arst_n being visible in the module that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define PLIH_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define PLIH_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

FILE: rtl/core/plih_pkg.sv
// Package for the photon lifetime image histogram: constants, codes, types.
// No dependencies.
`default_nettype none
package plih_pkg;
	localparam int unsigned HIST_DEPTH     = 65536;
	localparam int unsigned ADDR_BITS      = 16;
	localparam int unsigned OUT_BITS       = 16;
	localparam int unsigned MICRO_BITS     = 15;
	localparam int unsigned BW_BITS        = 16;
	localparam int unsigned LANES          = 3;

	localparam int unsigned MAX_WIDTH_DEF  = 64;
	localparam int unsigned MAX_LINES_DEF  = 64;
	localparam int unsigned TIME_BINS_DEF  = 16;
	localparam int unsigned COUNT_BITS_DEF = 16;

	localparam logic [7:0] CH_LINE_START = 8'd65;
	localparam logic [7:0] CH_LINE_STOP  = 8'd66;
	localparam logic [7:0] CH_FRAME      = 8'd68;

	localparam logic [1:0] USE_GREEN_RED = 2'd1;
	localparam logic [1:0] USE_YELLOW    = 2'd2;

	localparam logic [1:0] IMG_GREEN  = 2'd0;
	localparam logic [1:0] IMG_RED    = 2'd1;
	localparam logic [1:0] IMG_YELLOW = 2'd2;

	localparam logic CMD_RECORD = 1'b0;
	localparam logic CMD_READ   = 1'b1;

	localparam logic [6:0] LINE_SAT = 7'd127;

	typedef enum logic [2:0] {
		REG_IMAGE_WIDTH     = 3'd0,
		REG_TAC_BIN_WIDTH   = 3'd1,
		REG_PIXEL_SCALE     = 3'd2,
		REG_LINES_PER_GROUP = 3'd3,
		REG_LINE_USE_CODES  = 3'd4,
		REG_GREEN_CHANNELS  = 3'd5,
		REG_RED_CHANNELS    = 3'd6,
		REG_YELLOW_CHANNELS = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;
endpackage
`default_nettype wire

FILE: rtl/core/plih_ifs.sv
// Handshake channels of the histogram block: record/command input, count output.
// Depends on nothing.
`default_nettype none
interface plih_rec_if;
	logic        valid;
	logic        ready;
	logic        command;
	logic [7:0]  channel;
	logic [14:0] microtime;
	logic [31:0] macrotime;
	logic [1:0]  read_image;
	logic [15:0] read_address;
	modport source (output valid, command, channel, microtime, macrotime, read_image,
		read_address, input ready);
	modport sink (input valid, command, channel, microtime, macrotime, read_image,
		read_address, output ready);
endinterface

interface plih_cnt_if;
	logic        valid;
	logic        ready;
	logic [15:0] read_count;
	modport source (output valid, read_count, input ready);
	modport sink (input valid, read_count, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/photon_lifetime_image_histogram.sv
// Photon lifetime image histogram top level.
// Depends on plih_pkg, plih_ifs, plih_bin_div, plih_hist_ram, assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
// Takes time-tagged photon records and read commands on rec, returns counts on cnt.
// Green, red and yellow counts share one memory row per histogram address, so a
// photon is one read-modify-write of one row. After reset the block clears the
// memory, one row a cycle, and accepts no item meanwhile (configuration writes are
// taken). Line markers, frame markers, ignored records and photons outside a line
// are handled in S_IDLE. A counted photon passes the pixel multiply, the bin
// divider that yields one quotient bit per cycle (15 bits), the address stage with
// the row read and the write back. A read command reads its row and holds until
// the output register is free; its count waits there and the next item is accepted
// while it waits. Configuration is to be written through the APB port while the
// block is idle, which it does not enforce; register i lies at byte address 4*i.
module photon_lifetime_image_histogram #(
	parameter int unsigned MAX_WIDTH  = plih_pkg::MAX_WIDTH_DEF,
	parameter int unsigned MAX_LINES  = plih_pkg::MAX_LINES_DEF,
	parameter int unsigned TIME_BINS  = plih_pkg::TIME_BINS_DEF,
	parameter int unsigned COUNT_BITS = plih_pkg::COUNT_BITS_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [4:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready,
	plih_rec_if.sink         rec,
	plih_cnt_if.source       cnt
);
	localparam int unsigned ROW_W = plih_pkg::LANES * COUNT_BITS;
	localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

	typedef enum logic [6:0] {
		S_CLEAR = 7'b0000001,
		S_IDLE  = 7'b0000010,
		S_MUL   = 7'b0000100,
		S_DIV   = 7'b0001000,
		S_ADDR  = 7'b0010000,
		S_BUMP  = 7'b0100000,
		S_OUT   = 7'b1000000
	} state_t;

	state_t state_q;

	// Configuration registers.
	logic [6:0]  image_width_q;
	logic [15:0] tac_bin_width_q;
	logic [31:0] pixel_scale_q;
	logic [3:0]  lines_per_group_q;
	logic [15:0] line_use_codes_q;
	logic [15:0] green_channels_q, red_channels_q, yellow_channels_q;

	// Scan state.
	logic        in_scan_q;
	logic [31:0] line_start_q;
	logic [2:0]  lig_q;
	logic [6:0]  image_line_q;

	// Photon work registers.
	logic [31:0] diff_q;
	logic [63:0] prod_q;
	logic [6:0]  line_q;
	logic [1:0]  lane_q;
	logic [1:0]  rimg_q;
	logic [14:0] lp_q;
	logic        pix_ok_q;
	logic [15:0] addr_q;
	logic [16:0] clr_q;

	logic        out_valid_q;
	logic [15:0] out_count_q;

	// Write pulse on the APB access phase.
	logic cfg_we;
	assign cfg_we = psel && penable && pwrite;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q     <= 7'd64;
			tac_bin_width_q   <= 16'd2048;
			pixel_scale_q     <= 32'h0100_0000;
			lines_per_group_q <= 4'd1;
			line_use_codes_q  <= 16'd1;
			green_channels_q  <= '0;
			red_channels_q    <= '0;
			yellow_channels_q <= '0;
		end else if (cfg_we) begin
			unique case (plih_pkg::reg_idx_t'(paddr[4:2]))
				plih_pkg::REG_IMAGE_WIDTH:     image_width_q     <= pwdata[6:0];
				plih_pkg::REG_TAC_BIN_WIDTH:   tac_bin_width_q   <= pwdata[15:0];
				plih_pkg::REG_PIXEL_SCALE:     pixel_scale_q     <= pwdata;
				plih_pkg::REG_LINES_PER_GROUP: lines_per_group_q <= pwdata[3:0];
				plih_pkg::REG_LINE_USE_CODES:  line_use_codes_q  <= pwdata[15:0];
				plih_pkg::REG_GREEN_CHANNELS:  green_channels_q  <= pwdata[15:0];
				plih_pkg::REG_RED_CHANNELS:    red_channels_q    <= pwdata[15:0];
				plih_pkg::REG_YELLOW_CHANNELS: yellow_channels_q <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (plih_pkg::reg_idx_t'(paddr[4:2]))
			plih_pkg::REG_IMAGE_WIDTH:     prdata = 32'(image_width_q);
			plih_pkg::REG_TAC_BIN_WIDTH:   prdata = 32'(tac_bin_width_q);
			plih_pkg::REG_PIXEL_SCALE:     prdata = pixel_scale_q;
			plih_pkg::REG_LINES_PER_GROUP: prdata = 32'(lines_per_group_q);
			plih_pkg::REG_LINE_USE_CODES:  prdata = 32'(line_use_codes_q);
			plih_pkg::REG_GREEN_CHANNELS:  prdata = 32'(green_channels_q);
			plih_pkg::REG_RED_CHANNELS:    prdata = 32'(red_channels_q);
			plih_pkg::REG_YELLOW_CHANNELS: prdata = 32'(yellow_channels_q);
			default:                       prdata = '0;
		endcase
	end

	// Record decode at the input.
	logic       acc;
	logic       is_read, is_start, is_stop, is_frame;
	logic [1:0] use_code;
	logic       hit_g, hit_r, hit_y, hit_any;
	logic [1:0] hit_lane;

	assign rec.ready = (state_q == S_IDLE);
	assign acc       = rec.valid && rec.ready;
	assign is_read   = (rec.command == plih_pkg::CMD_READ);
	assign is_start  = (rec.channel == plih_pkg::CH_LINE_START);
	assign is_stop   = (rec.channel == plih_pkg::CH_LINE_STOP);
	assign is_frame  = (rec.channel == plih_pkg::CH_FRAME);
	assign use_code  = line_use_codes_q[{lig_q, 1'b0} +: 2];

	assign hit_g = ((rec.channel == green_channels_q[7:0]) ||
		(rec.channel == green_channels_q[15:8])) && (use_code == plih_pkg::USE_GREEN_RED);
	assign hit_r = ((rec.channel == red_channels_q[7:0]) ||
		(rec.channel == red_channels_q[15:8])) && (use_code == plih_pkg::USE_GREEN_RED);
	assign hit_y = ((rec.channel == yellow_channels_q[7:0]) ||
		(rec.channel == yellow_channels_q[15:8])) && (use_code == plih_pkg::USE_YELLOW);
	assign hit_any = hit_g || hit_r || hit_y;

	always_comb begin
		priority if (hit_g) begin
			hit_lane = plih_pkg::IMG_GREEN;
		end else if (hit_r) begin
			hit_lane = plih_pkg::IMG_RED;
		end else begin
			hit_lane = plih_pkg::IMG_YELLOW;
		end
	end

	logic photon_go;
	assign photon_go = acc && !is_read && !is_start && !is_stop && !is_frame &&
		in_scan_q && hit_any;

	// Group size clamp: 0 acts as 1, above 8 acts as 8.
	logic [3:0] lpg, lig_next;
	assign lpg = (lines_per_group_q == 4'd0) ? 4'd1 :
		((lines_per_group_q > 4'd8) ? 4'd8 : lines_per_group_q);
	assign lig_next = {1'b0, lig_q} + 4'd1;

	// Divider for the time bin.
	plih_pkg::div_stat_t     div_stat;
	logic [14:0]             quo;

	plih_bin_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (photon_go),
		.num    (rec.microtime),
		.den    (tac_bin_width_q),
		.stat   (div_stat),
		.quo    (quo)
	);

	// Pixel and address arithmetic.
	logic [6:0]  w_eff;
	logic [39:0] pixel;
	logic [31:0] addr_full;
	logic        addr_ok;

	assign w_eff = (32'(image_width_q) < MAX_WIDTH) ? image_width_q : 7'(MAX_WIDTH);
	assign pixel = prod_q[63:24];
	assign addr_full = 32'(lp_q) * 32'(TIME_BINS) + 32'(quo);
	assign addr_ok = pix_ok_q && (tac_bin_width_q != 16'd0) && (32'(quo) < TIME_BINS) &&
		(32'(line_q) < MAX_LINES) && (addr_full < plih_pkg::HIST_DEPTH);

	// Memory ports.
	logic                               mem_we, mem_re;
	logic [plih_pkg::ADDR_BITS-1:0]     mem_waddr, mem_raddr;
	logic [ROW_W-1:0]                   mem_wdata, mem_rdata;
	logic [COUNT_BITS-1:0]              cur_cnt, new_cnt;

	assign cur_cnt = mem_rdata[lane_q * COUNT_BITS +: COUNT_BITS];
	assign new_cnt = (cur_cnt == CNT_MAX) ? cur_cnt : cur_cnt + 1'b1;

	always_comb begin
		mem_wdata = mem_rdata;
		mem_wdata[lane_q * COUNT_BITS +: COUNT_BITS] = new_cnt;
		if (state_q == S_CLEAR) begin
			mem_wdata = '0;
		end
	end

	assign mem_we    = (state_q == S_CLEAR) || (state_q == S_BUMP);
	assign mem_waddr = (state_q == S_CLEAR) ? clr_q[plih_pkg::ADDR_BITS-1:0] : addr_q;
	assign mem_re    = (acc && is_read) || ((state_q == S_ADDR) && addr_ok);
	assign mem_raddr = (state_q == S_ADDR) ? addr_full[plih_pkg::ADDR_BITS-1:0]
		: rec.read_address;

	plih_hist_ram #(
		.DATA_W (ROW_W),
		.DEPTH  (plih_pkg::HIST_DEPTH),
		.ADDR_W (plih_pkg::ADDR_BITS)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// Selected count for a read command; image code 3 reads as zero.
	logic [15:0] rd_sel;
	always_comb begin
		unique case (rimg_q)
			plih_pkg::IMG_GREEN:  rd_sel = 16'(mem_rdata[0 +: COUNT_BITS]);
			plih_pkg::IMG_RED:    rd_sel = 16'(mem_rdata[COUNT_BITS +: COUNT_BITS]);
			plih_pkg::IMG_YELLOW: rd_sel = 16'(mem_rdata[2*COUNT_BITS +: COUNT_BITS]);
			default:              rd_sel = '0;
		endcase
	end

	logic out_free;
	assign out_free = !out_valid_q || cnt.ready;

	// Sequencer and scan state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLEAR;
			clr_q        <= '0;
			in_scan_q    <= 1'b0;
			line_start_q <= '0;
			lig_q        <= '0;
			image_line_q <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			// Load a new count from S_OUT, else hold a count until its transfer.
			out_valid_q <= ((state_q == S_OUT) && out_free) || (out_valid_q && !cnt.ready);
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 17'd1;
					if (clr_q == 17'(plih_pkg::HIST_DEPTH - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (acc) begin
						priority if (is_read) begin
							state_q <= S_OUT;
						end else if (is_start) begin
							in_scan_q    <= 1'b1;
							line_start_q <= rec.macrotime;
						end else if (is_stop) begin
							in_scan_q <= 1'b0;
							if (lig_next >= lpg) begin
								lig_q <= '0;
								if (image_line_q < plih_pkg::LINE_SAT) begin
									image_line_q <= image_line_q + 7'd1;
								end
							end else begin
								lig_q <= lig_next[2:0];
							end
						end else if (is_frame) begin
							image_line_q <= '0;
						end else if (photon_go) begin
							state_q <= S_MUL;
						end else begin
							state_q <= S_IDLE;
						end
					end
				end
				S_MUL:  state_q <= S_DIV;
				S_DIV: begin
					if (div_stat.done) begin
						state_q <= S_ADDR;
					end
				end
				S_ADDR: state_q <= addr_ok ? S_BUMP : S_IDLE;
				S_BUMP: state_q <= S_IDLE;
				S_OUT: begin
					// Hold the count until the output register is free.
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (photon_go) begin
			diff_q <= rec.macrotime - line_start_q;
			line_q <= image_line_q;
			lane_q <= hit_lane;
		end
		if (acc && is_read) begin
			rimg_q <= rec.read_image;
		end
		if (state_q == S_MUL) begin
			prod_q <= 64'(diff_q) * 64'(pixel_scale_q);
		end
		if (state_q == S_DIV) begin
			pix_ok_q <= pixel < 40'(w_eff);
			lp_q     <= 15'(line_q) * 15'(w_eff) + 15'(pixel[6:0]);
		end
		if (state_q == S_ADDR) begin
			addr_q <= addr_full[plih_pkg::ADDR_BITS-1:0];
		end
		if ((state_q == S_OUT) && out_free) begin
			out_count_q <= rd_sel;
		end
	end

	assign cnt.valid      = out_valid_q;
	assign cnt.read_count = out_count_q;

	`PLIH_ASSERT_IMP(a_no_accept_in_clear, state_q == S_CLEAR, !rec.ready)
	`PLIH_ASSERT_IMP(a_we_only_clear_bump, mem_we, (state_q == S_CLEAR) || (state_q == S_BUMP))
	`PLIH_ASSERT_NXT(a_addr_ok_bumps, (state_q == S_ADDR) && addr_ok, state_q == S_BUMP)
	`PLIH_ASSERT_IMP(a_div_done_in_div, div_stat.done, state_q == S_DIV)
endmodule
`default_nettype wire

FILE: rtl/core/plih_bin_div.sv
// Restoring divider, one quotient bit per cycle: microtime / bin width.
// Depends on plih_pkg.
`default_nettype none
module plih_bin_div (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               start,
	input  wire logic [plih_pkg::MICRO_BITS-1:0]    num,
	input  wire logic [plih_pkg::BW_BITS-1:0]       den,
	output plih_pkg::div_stat_t                     stat,
	output logic      [plih_pkg::MICRO_BITS-1:0]    quo
);
	logic                              busy_q, done_q;
	logic [3:0]                        cnt_q;
	logic [plih_pkg::BW_BITS-1:0]      rem_q, den_q;
	logic [plih_pkg::MICRO_BITS-1:0]   num_q;
	logic [plih_pkg::BW_BITS:0]        trial;
	logic                              take;

	assign trial = {rem_q, num_q[plih_pkg::MICRO_BITS-1]};
	assign take  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 4'(plih_pkg::MICRO_BITS - 1);
			end else if (busy_q) begin
				if (cnt_q == 4'd0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q - 4'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			num_q <= num;
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= take ? plih_pkg::BW_BITS'(trial - {1'b0, den_q})
				: trial[plih_pkg::BW_BITS-1:0];
			num_q <= {num_q[plih_pkg::MICRO_BITS-2:0], take};
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quo       = num_q;
endmodule
`default_nettype wire

FILE: rtl/core/plih_hist_ram.sv
// Histogram row memory: one write port, one registered read port.
// Depends on nothing.
`default_nettype none
module plih_hist_ram #(
	parameter int unsigned DATA_W = 48,
	parameter int unsigned DEPTH  = 65536,
	parameter int unsigned ADDR_W = 16
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire logic [DATA_W-1:0] wdata,
	input  wire logic              re,
	input  wire logic [ADDR_W-1:0] raddr,
	output logic      [DATA_W-1:0] rdata
);
	logic [DATA_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule
`default_nettype wire
